[sv/bdage_pkg.sv]
`timescale 1ns / 1ps

package bdage_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 12;
    localparam int WDAY_W    = 3;
    localparam int DAYS_W    = 17;
    localparam int AGE_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [YEAR_W-1:0] MIN_YEAR   = 12'd1901;
    localparam logic [DAYS_W-1:0] WALK_LIMIT = 17'd72685;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_YEAR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TODAY_WDAY  = 2'd3;

    localparam logic [DAY_W-1:0]   RST_TODAY_DAY   = 5'd27;
    localparam logic [MONTH_W-1:0] RST_TODAY_MONTH = 4'd2;
    localparam logic [YEAR_W-1:0]  RST_TODAY_YEAR  = 12'd2017;
    localparam logic [WDAY_W-1:0]  RST_TODAY_WDAY  = 3'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 2'd3;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  weekday;
    } date_t;

    // leap year every fourth year; unknown month codes count as February
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] m,
        input logic [YEAR_W-1:0]  y
    );
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11:
                    len = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
                    len = 5'd31;
                default:
                    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
            endcase
            return len;
        end
    endfunction

endpackage

[sv/bdage_step.sv]
`timescale 1ns / 1ps

// Steps a calendar date and its weekday back by one day.
module bdage_step
    import bdage_pkg::*;
(
    input  date_t cur,
    output date_t prev
);

    logic [MONTH_W-1:0] pm;

    assign pm = (cur.month == 4'd1) ? 4'd12 : cur.month - 4'd1;

    always_comb
    begin
        prev = cur;
        if (cur.day != 5'd1)
        begin
            prev.day = cur.day - 5'd1;
        end
        else
        begin
            prev.day   = month_length(pm, cur.year);
            prev.month = pm;
            if (cur.month == 4'd1)
            begin
                prev.year = cur.year - 12'd1;
            end
        end
        prev.weekday = (cur.weekday == 3'd1) ? 3'd7 : cur.weekday - 3'd1;
    end

endmodule

[sv/birth_date_age_weekday_days.sv]
`timescale 1ns / 1ps

// Birth date to age, weekday of birth and days lived. Starting from the
// configured today date and weekday, the block steps the calendar back one
// day per clock through a single date-decrement unit until it meets the
// birth date. A word that passes the range checks goes to the walk state; one
// that fails them goes straight to S_DONE, which registers the result with
// out_valid once the output is free. in_ready is low while a word is in work.
// Status: 0 ok, 1 bad day, 2 bad month, 3 bad year or date after today;
// on an error the other result fields are zero. Leap years are every fourth
// year. Write the today registers only while the block is idle.
module birth_date_age_weekday_days
    import bdage_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DAY_W-1:0]     birth_day,
    input  logic [MONTH_W-1:0]   birth_month,
    input  logic [YEAR_W-1:0]    birth_year,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [AGE_W-1:0]     age_years,
    output logic [WDAY_W-1:0]    birth_weekday,
    output logic [DAYS_W-1:0]    days_lived
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    date_t today_reg;

    date_t              walk_reg, walk_next;
    date_t              walk_prev;
    logic [DAYS_W-1:0]  day_count_reg, day_count_next;
    logic [AGE_W-1:0]   age_count_reg, age_count_next;

    logic [DAY_W-1:0]   bday_reg;
    logic [MONTH_W-1:0] bmonth_reg;
    logic [YEAR_W-1:0]  byear_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AGE_W-1:0]    age_reg;
    logic [WDAY_W-1:0]   wday_reg;
    logic [DAYS_W-1:0]   days_reg;

    logic                in_acc;
    logic [STATUS_W-1:0] chk_status;
    logic                md_match;
    logic                full_match;
    logic                out_free;
    logic                res_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign res_ok   = (res_status_reg == ST_OK);

    always_comb
    begin
        if (birth_day == 5'd0)
            chk_status = ST_BAD_DAY;
        else if (birth_month == 4'd0 || birth_month > 4'd12)
            chk_status = ST_BAD_MONTH;
        else if (birth_year < MIN_YEAR || birth_year > today_reg.year)
            chk_status = ST_BAD_YEAR;
        else if (birth_day > month_length(birth_month, birth_year))
            chk_status = ST_BAD_DAY;
        else
            chk_status = ST_OK;
    end

    bdage_step u_step (
        .cur  (walk_reg),
        .prev (walk_prev)
    );

    assign md_match   = (walk_reg.month == bmonth_reg) && (walk_reg.day == bday_reg);
    assign full_match = md_match && (walk_reg.year == byear_reg);

    always_comb
    begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        day_count_next  = day_count_reg;
        age_count_next  = age_count_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_status_next = chk_status;
                    if (chk_status == ST_OK)
                    begin
                        walk_next      = today_reg;
                        day_count_next = '0;
                        age_count_next = '0;
                        state_next     = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (full_match)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else if (day_count_reg >= WALK_LIMIT)
                begin
                    // never reached: birth date lies after today
                    res_status_next = ST_BAD_YEAR;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (md_match)
                        age_count_next = age_count_reg + 8'd1;
                    walk_next      = walk_prev;
                    day_count_next = day_count_reg + 17'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            walk_reg       <= '0;
            day_count_reg  <= '0;
            age_count_reg  <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            day_count_reg  <= day_count_next;
            age_count_reg  <= age_count_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            today_reg.day     <= RST_TODAY_DAY;
            today_reg.month   <= RST_TODAY_MONTH;
            today_reg.year    <= RST_TODAY_YEAR;
            today_reg.weekday <= RST_TODAY_WDAY;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_TODAY_DAY:   today_reg.day     <= cfg_data[DAY_W-1:0];
                REG_TODAY_MONTH: today_reg.month   <= cfg_data[MONTH_W-1:0];
                REG_TODAY_YEAR:  today_reg.year    <= cfg_data[YEAR_W-1:0];
                REG_TODAY_WDAY:  today_reg.weekday <= cfg_data[WDAY_W-1:0];
                default:         today_reg         <= today_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            bday_reg   <= birth_day;
            bmonth_reg <= birth_month;
            byear_reg  <= birth_year;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            status_reg <= res_status_reg;
            age_reg    <= res_ok ? age_count_reg : '0;
            wday_reg   <= res_ok ? walk_reg.weekday : '0;
            days_reg   <= res_ok ? day_count_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign age_years     = age_reg;
    assign birth_weekday = wday_reg;
    assign days_lived    = days_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
            age_years == '0 && birth_weekday == '0 && days_lived == '0)
        else $error("error word carries nonzero result fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> day_count_reg <= WALK_LIMIT)
        else $error("walk ran past its step limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new word taken while previous one in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && !full_match && day_count_reg < WALK_LIMIT |=>
            day_count_reg == $past(day_count_reg) + 17'd1)
        else $error("day counter did not follow the date step");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bdage_pkg::*;

    localparam int QUIET_LIMIT = 250000;
    // cost ceiling for an ordinary random word; long walks are rationed apart
    localparam int SHORT_WALK_MAX = 4000;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } birth_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AGE_W-1:0]    age;
        logic [WDAY_W-1:0]   weekday;
        logic [DAYS_W-1:0]   days;
    } age_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [DAY_W-1:0]     birth_day = '0;
    logic [MONTH_W-1:0]   birth_month = '0;
    logic [YEAR_W-1:0]    birth_year = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [AGE_W-1:0]     age_years;
    logic [WDAY_W-1:0]    birth_weekday;
    logic [DAYS_W-1:0]    days_lived;

    // mirror of the today registers
    logic [DAY_W-1:0]   today_d  = RST_TODAY_DAY;
    logic [MONTH_W-1:0] today_m  = RST_TODAY_MONTH;
    logic [YEAR_W-1:0]  today_y  = RST_TODAY_YEAR;
    logic [WDAY_W-1:0]  today_wd = RST_TODAY_WDAY;

    // calendar walk state
    logic [DAY_W-1:0]   walk_d = '0;
    logic [MONTH_W-1:0] walk_m = '0;
    logic [YEAR_W-1:0]  walk_y = '0;
    logic [WDAY_W-1:0]  walk_wd = '0;
    logic [DAYS_W-1:0]  walked_days = '0;
    logic [AGE_W-1:0]   birthdays_seen = '0;

    birth_t      pending_births[$];
    age_result_t expected_ages[$];
    birth_t      next_birth;
    birth_t      accepted_birth;
    age_result_t got_age;
    age_result_t want_age;
    int unsigned walk_steps;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          pace_sel = 0;
    int          long_walks_left = 4;
    int          error_count = 0;
    int          quiet_cycles = 0;

    birth_date_age_weekday_days u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .birth_day     (birth_day),
        .birth_month   (birth_month),
        .birth_year    (birth_year),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .age_years     (age_years),
        .birth_weekday (birth_weekday),
        .days_lived    (days_lived)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // every fourth year is leap; month codes outside 1..12 behave as February
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0] y);
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
            return 5'd30;
        if (m == 4'd2 || m == 4'd0 || m > 4'd12)
            return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
        return 5'd31;
    endfunction

    function automatic void start_at_today();
        walk_d = today_d;
        walk_m = today_m;
        walk_y = today_y;
        walk_wd = today_wd;
        walked_days = '0;
        birthdays_seen = '0;
    endfunction

    function automatic void step_back_one_day();
        logic [MONTH_W-1:0] pm;
        pm = (walk_m == 4'd1) ? 4'd12 : walk_m - 4'd1;
        if (walk_d != 5'd1)
            walk_d = walk_d - 5'd1;
        else
        begin
            walk_d = days_in_month(pm, walk_y);
            if (walk_m == 4'd1)
                walk_y = walk_y - 12'd1;
            walk_m = pm;
        end
        walk_wd = (walk_wd == 3'd1) ? 3'd7 : walk_wd - 3'd1;
        walked_days = walked_days + 1'b1;
    endfunction

    function automatic age_result_t predict_age(input birth_t b, output int unsigned steps);
        age_result_t r;
        r = '0;
        steps = 0;
        if (b.day == 5'd0)
            r.status = ST_BAD_DAY;
        else if (b.month == 4'd0 || b.month > 4'd12)
            r.status = ST_BAD_MONTH;
        else if (b.year < MIN_YEAR || b.year > today_y)
            r.status = ST_BAD_YEAR;
        else if (b.day > days_in_month(b.month, b.year))
            r.status = ST_BAD_DAY;
        if (r.status != ST_OK)
            return r;
        start_at_today();
        while (!(walk_y == b.year && walk_m == b.month && walk_d == b.day)
               && steps < WALK_LIMIT)
        begin
            if (walk_m == b.month && walk_d == b.day)
                birthdays_seen = birthdays_seen + 1'b1;
            step_back_one_day();
            steps++;
        end
        if (walk_y == b.year && walk_m == b.month && walk_d == b.day)
        begin
            r.age = birthdays_seen;
            r.weekday = walk_wd;
            r.days = walked_days;
        end
        else
            r.status = ST_BAD_YEAR;
        return r;
    endfunction

    // mostly reachable dates a short walk back from today, a few long walks,
    // plus plausible-looking dates and raw noise that are kept cheap to walk
    function automatic birth_t random_birth();
        birth_t      b;
        int unsigned kind;
        int unsigned back;
        int unsigned steps;
        bit          long_walk;
        do
        begin
            kind = $urandom_range(99);
            long_walk = (kind >= 60 && kind < 65 && long_walks_left > 0);
            if (kind < 65)
            begin
                start_at_today();
                back = long_walk ? $urandom_range(72684, 1500) : $urandom_range(1500, 0);
                repeat (back) step_back_one_day();
                b = '{walk_d, walk_m, walk_y};
            end
            else if (kind < 85)
            begin
                b.day = DAY_W'($urandom_range(31, 1));
                b.month = MONTH_W'($urandom_range(12, 1));
                b.year = today_y - YEAR_W'($urandom_range(4, 0));
            end
            else
            begin
                b.day = DAY_W'($urandom);
                b.month = MONTH_W'($urandom);
                b.year = YEAR_W'($urandom);
            end
            void'(predict_age(b, steps));
        end while (steps > SHORT_WALK_MAX && !long_walk);
        if (long_walk)
            long_walks_left--;
        return b;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic push_birth(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                              input logic [YEAR_W-1:0] y);
        pending_births.push_back('{d, m, y});
    endtask

    task automatic next_pacing();
        case (pace_sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        pace_sel++;
    endtask

    task automatic run_random(input int chunks);
        repeat (chunks)
        begin
            next_pacing();
            repeat (10) pending_births.push_back(random_birth());
            while (pending_births.size() > 0)
                @(posedge clk);
        end
    endtask

    // block is idle once every word is in and every result is out
    task automatic drain();
        while (pending_births.size() > 0 || in_valid || expected_ages.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_today(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                             input logic [YEAR_W-1:0] y, input logic [WDAY_W-1:0] wd);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_addr <= REG_TODAY_DAY;
        cfg_data <= CFG_DAT_W'(d);
        @(posedge clk);
        cfg_addr <= REG_TODAY_MONTH;
        cfg_data <= CFG_DAT_W'(m);
        @(posedge clk);
        cfg_addr <= REG_TODAY_YEAR;
        cfg_data <= CFG_DAT_W'(y);
        @(posedge clk);
        cfg_addr <= REG_TODAY_WDAY;
        cfg_data <= CFG_DAT_W'(wd);
        @(posedge clk);
        cfg_en <= 1'b0;
        today_d = d;
        today_m = m;
        today_y = y;
        today_wd = wd;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted_birth = '{day: birth_day, month: birth_month, year: birth_year};
                expected_ages.push_back(predict_age(accepted_birth, walk_steps));
            end
            if ((!in_valid || in_ready) && pending_births.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_birth = pending_births.pop_front();
                in_valid <= 1'b1;
                birth_day <= next_birth.day;
                birth_month <= next_birth.month;
                birth_year <= next_birth.year;
            end
            else if (in_valid && in_ready)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_age = '{status, age_years, birth_weekday, days_lived};
                if (expected_ages.size() == 0)
                    flag_mismatch("result word with nothing expected");
                else
                begin
                    want_age = expected_ages.pop_front();
                    if (got_age.status !== want_age.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                got_age.status, want_age.status));
                    if (got_age.age !== want_age.age)
                        flag_mismatch($sformatf("age_years %0d, want %0d",
                                                got_age.age, want_age.age));
                    if (got_age.weekday !== want_age.weekday)
                        flag_mismatch($sformatf("birth_weekday %0d, want %0d",
                                                got_age.weekday, want_age.weekday));
                    if (got_age.days !== want_age.days)
                        flag_mismatch($sformatf("days_lived %0d, want %0d",
                                                got_age.days, want_age.days));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: fails the test if handshakes stop; a walk has no handshake while it runs
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // today from reset: 27 Feb 2017, Monday
        next_pacing();
        push_birth(5'd27, 4'd2, 12'd2017);   // today itself, zero days
        push_birth(5'd0, 4'd5, 12'd2000);
        push_birth(5'd31, 4'd15, 12'd4095);
        push_birth(5'd10, 4'd0, 12'd0);
        push_birth(5'd10, 4'd13, 12'd2000);
        push_birth(5'd10, 4'd5, 12'd1900);
        push_birth(5'd10, 4'd5, 12'd0);
        push_birth(5'd1, 4'd1, 12'd2018);
        push_birth(5'd31, 4'd4, 12'd2010);   // no 31st in April
        push_birth(5'd29, 4'd2, 12'd2015);   // Feb 29 in a common year
        push_birth(5'd30, 4'd2, 12'd2016);
        push_birth(5'd29, 4'd2, 12'd2016);
        push_birth(5'd29, 4'd2, 12'd2000);   // leap-day birthday, age counts leap years only
        push_birth(5'd28, 4'd2, 12'd2017);   // day after today walks to the limit
        push_birth(5'd27, 4'd2, 12'd2016);
        push_birth(5'd31, 4'd12, 12'd2016);
        push_birth(5'd1, 4'd1, 12'd1901);
        drain();
        run_random(2);
        drain();

        // latest today, longest possible walk
        set_today(5'd31, 4'd12, 12'd2099, 3'd7);
        next_pacing();
        push_birth(5'd1, 4'd1, 12'd1901);
        push_birth(5'd31, 4'd12, 12'd2099);
        push_birth(5'd1, 4'd1, 12'd2099);
        drain();
        run_random(2);
        drain();

        // earliest today
        set_today(5'd1, 4'd1, 12'd1901, 3'd1);
        next_pacing();
        push_birth(5'd1, 4'd1, 12'd1901);
        push_birth(5'd31, 4'd12, 12'd1900);
        drain();
        run_random(1);
        drain();

        // out-of-range today: day 0, month 15, weekday 0 are taken as they are
        set_today(5'd0, 4'd15, 12'd2000, 3'd0);
        next_pacing();
        push_birth(5'd31, 4'd12, 12'd2000);
        push_birth(5'd1, 4'd12, 12'd2000);
        push_birth(5'd30, 4'd13, 12'd2000);
        drain();
        run_random(1);
        drain();

        set_today(5'd15, 4'd6, 12'd2050, 3'd4);
        run_random(4);
        drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
